// ===== rtl/core/cspc_pkg.sv =====
// shared constants and types for the cigar string parser and counter
package cspc_pkg;

    localparam int LEN_WIDTH   = 31;
    localparam int COUNT_WIDTH = 16;
    localparam int CHAR_WIDTH  = 8;

    localparam logic [CHAR_WIDTH-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CASE_DELTA = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_M     = 8'h4D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_I     = 8'h49;
    localparam logic [CHAR_WIDTH-1:0] CHAR_D     = 8'h44;
    localparam logic [CHAR_WIDTH-1:0] CHAR_N     = 8'h4E;
    localparam logic [CHAR_WIDTH-1:0] CHAR_S     = 8'h53;
    localparam logic [CHAR_WIDTH-1:0] CHAR_H     = 8'h48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_P     = 8'h50;
    localparam logic [CHAR_WIDTH-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_X     = 8'h58;

    typedef enum logic [3:0] {
        OP_M  = 4'd0,
        OP_I  = 4'd1,
        OP_D  = 4'd2,
        OP_N  = 4'd3,
        OP_S  = 4'd4,
        OP_H  = 4'd5,
        OP_P  = 4'd6,
        OP_EQ = 4'd7,
        OP_X  = 4'd8
    } op_code_t;

    typedef struct packed {
        logic     is_digit;
        logic [3:0] digit;
        logic     op_valid;
        op_code_t op_code;
        logic     add_ref;
        logic     add_ins;
        logic     add_del;
    } dec_t;

    typedef struct packed {
        op_code_t               op_code;
        logic                   op_valid;
        logic [LEN_WIDTH-1:0]   op_length;
        logic [LEN_WIDTH-1:0]   ref_total;
        logic [LEN_WIDTH-1:0]   insert_total;
        logic [LEN_WIDTH-1:0]   delete_total;
        logic [COUNT_WIDTH-1:0] element_count;
        logic                   string_done;
    } result_t;

endpackage

// ===== rtl/core/cspc_if.sv =====
// valid/ready channels for characters in and parsed elements out
interface cspc_char_if
    import cspc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_in;
    logic                  end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface cspc_elem_if
    import cspc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    op_code_t               op_code;
    logic                   op_valid;
    logic [LEN_WIDTH-1:0]   op_length;
    logic [LEN_WIDTH-1:0]   ref_total;
    logic [LEN_WIDTH-1:0]   insert_total;
    logic [LEN_WIDTH-1:0]   delete_total;
    logic [COUNT_WIDTH-1:0] element_count;
    logic                   string_done;

    modport source (
        output valid, output op_code, output op_valid, output op_length,
        output ref_total, output insert_total, output delete_total,
        output element_count, output string_done, input ready
    );
    modport sink (
        input valid, input op_code, input op_valid, input op_length,
        input ref_total, input insert_total, input delete_total,
        input element_count, input string_done, output ready
    );
endinterface

// ===== rtl/core/cspc_decode.sv =====
// character classifier: digit detection and operator decode
module cspc_decode
    import cspc_pkg::*;
(
    input  logic [CHAR_WIDTH-1:0] char_in,
    output dec_t                  dec
);

    logic [CHAR_WIDTH-1:0] upper;
    logic [CHAR_WIDTH-1:0] digit_wide;

    always_comb
    begin
        upper = char_in;
        if (char_in >= CHAR_LO_A && char_in <= CHAR_LO_Z)
        begin
            upper = char_in - CASE_DELTA;
        end
        digit_wide = char_in - CHAR_0;

        dec.is_digit = (char_in >= CHAR_0) && (char_in <= CHAR_9);
        dec.digit    = digit_wide[3:0];
        dec.op_valid = 1'b1;
        dec.op_code  = OP_M;
        case (upper)
            CHAR_M:  dec.op_code = OP_M;
            CHAR_I:  dec.op_code = OP_I;
            CHAR_D:  dec.op_code = OP_D;
            CHAR_N:  dec.op_code = OP_N;
            CHAR_S:  dec.op_code = OP_S;
            CHAR_H:  dec.op_code = OP_H;
            CHAR_P:  dec.op_code = OP_P;
            CHAR_EQ: dec.op_code = OP_EQ;
            CHAR_X:  dec.op_code = OP_X;
            default: dec.op_valid = 1'b0;
        endcase
        // a digit never ends an element
        if (dec.is_digit)
        begin
            dec.op_valid = 1'b0;
            dec.op_code  = OP_M;
        end

        dec.add_ref = dec.op_valid && (dec.op_code == OP_M || dec.op_code == OP_D ||
                      dec.op_code == OP_N || dec.op_code == OP_EQ || dec.op_code == OP_X);
        dec.add_ins = dec.op_valid && (dec.op_code == OP_I);
        dec.add_del = dec.op_valid && (dec.op_code == OP_D);
    end

endmodule

// ===== rtl/core/cspc_tally.sv =====
// run length accumulator and saturating running totals
module cspc_tally
    import cspc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  dec_t    dec,
    input  logic    last,
    output logic    emit,
    output result_t res
);

    localparam logic [LEN_WIDTH-1:0]   LEN_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [LEN_WIDTH-1:0]   accum_reg, accum_next;
    logic [LEN_WIDTH-1:0]   ref_reg, ref_next;
    logic [LEN_WIDTH-1:0]   ins_reg, ins_next;
    logic [LEN_WIDTH-1:0]   del_reg, del_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [LEN_WIDTH+3:0]   times_ten;
    logic [LEN_WIDTH-1:0]   accum_digit;
    logic [LEN_WIDTH-1:0]   len;
    logic [LEN_WIDTH-1:0]   ref_sum, ins_sum, del_sum;
    logic [COUNT_WIDTH-1:0] count_inc;

    function automatic logic [LEN_WIDTH-1:0] sat_add(
        input logic [LEN_WIDTH-1:0] a,
        input logic [LEN_WIDTH-1:0] b
    );
        logic [LEN_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_WIDTH] ? LEN_MAX : s[LEN_WIDTH-1:0];
    endfunction

    always_comb
    begin
        // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
        times_ten = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                  + {{LEN_WIDTH{1'b0}}, dec.digit};
        accum_digit = (times_ten > {4'b0, LEN_MAX}) ? LEN_MAX : times_ten[LEN_WIDTH-1:0];
        len = dec.is_digit ? accum_digit : accum_reg;

        ref_sum   = dec.add_ref ? sat_add(ref_reg, len) : ref_reg;
        ins_sum   = dec.add_ins ? sat_add(ins_reg, len) : ins_reg;
        del_sum   = dec.add_del ? sat_add(del_reg, len) : del_reg;
        count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;

        emit = !dec.is_digit || last;

        res.op_code       = dec.op_code;
        res.op_valid      = dec.op_valid;
        res.op_length     = len;
        res.ref_total     = ref_sum;
        res.insert_total  = ins_sum;
        res.delete_total  = del_sum;
        res.element_count = count_inc;
        res.string_done   = last;

        accum_next = accum_reg;
        ref_next   = ref_reg;
        ins_next   = ins_reg;
        del_next   = del_reg;
        count_next = count_reg;
        if (step)
        begin
            if (last)
            begin
                accum_next = '0;
                ref_next   = '0;
                ins_next   = '0;
                del_next   = '0;
                count_next = '0;
            end
            else if (dec.is_digit)
            begin
                accum_next = accum_digit;
            end
            else
            begin
                accum_next = '0;
                ref_next   = ref_sum;
                ins_next   = ins_sum;
                del_next   = del_sum;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            ref_reg   <= '0;
            ins_reg   <= '0;
            del_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
            ref_reg   <= ref_next;
            ins_reg   <= ins_next;
            del_reg   <= del_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/cigar_string_parser_counter_core.sv =====
// CIGAR string parser: one character word in per cycle, one element word out per operator.
// A character word is taken every cycle as long as the element output is not stalled; a word
// goes into an input register, is decoded and folded into the run length and totals as it
// leaves that register, and its element word (if any) is written into the output register
// at the same time. Digits update the run length and give no output word; any other
// character, and a digit marked as the end of the string, give one element word. Input ready
// depends combinationally on output ready through the input register's advance condition.
module cigar_string_parser_counter_core
    import cspc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cspc_char_if.sink    chars,
    cspc_elem_if.source  elems
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [CHAR_WIDTH-1:0] s1_char_reg;
    logic                  s1_last_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg;

    dec_t    dec;
    logic    emit;
    result_t res;
    logic    out_free;
    logic    s1_fire;
    logic    take;

    cspc_decode u_decode (
        .char_in (s1_char_reg),
        .dec     (dec)
    );

    cspc_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_fire),
        .dec   (dec),
        .last  (s1_last_reg),
        .emit  (emit),
        .res   (res)
    );

    always_comb
    begin
        out_free      = !out_valid_reg || elems.ready;
        // a digit word with no result never waits on the output side
        s1_fire       = s1_valid_reg && (!emit || out_free);
        chars.ready   = !s1_valid_reg || s1_fire;
        take          = chars.valid && chars.ready;
        s1_valid_next = take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        if (s1_fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (elems.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_char_reg <= chars.char_in;
            s1_last_reg <= chars.end_of_string;
        end
        if (s1_fire && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign elems.valid         = out_valid_reg;
    assign elems.op_code       = out_res_reg.op_code;
    assign elems.op_valid      = out_res_reg.op_valid;
    assign elems.op_length     = out_res_reg.op_length;
    assign elems.ref_total     = out_res_reg.ref_total;
    assign elems.insert_total  = out_res_reg.insert_total;
    assign elems.delete_total  = out_res_reg.delete_total;
    assign elems.element_count = out_res_reg.element_count;
    assign elems.string_done   = out_res_reg.string_done;

    // every element word counts at least itself
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        elems.valid |-> elems.element_count != '0)
        else $error("element word with zero element count");

    // an illegal operator reports code zero
    a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
        elems.valid && !elems.op_valid |-> elems.op_code == OP_M)
        else $error("invalid element carries a nonzero operator code");

    // a held input word stays put while the output side is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_char_reg)
                                     && $stable(s1_last_reg))
        else $error("input register lost a stalled word");

    // only insertions move the insert total within a string
    a_ins_only_on_i: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && emit && !(dec.op_valid && dec.op_code == OP_I)
            |-> res.insert_total == u_tally.ins_reg)
        else $error("insert total moved on a non-insert element");

endmodule
